@@ rtl/frm_pkg.sv @@
// types and constants shared by the fraction multiply and reduce unit
package frm_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int PROD_W        = 2 * OPERAND_WIDTH;
    localparam int OUT_W         = 32;
    localparam int STEP_W        = $clog2(PROD_W);

    typedef struct packed {
        logic signed [OPERAND_WIDTH-1:0] a_num;
        logic signed [OPERAND_WIDTH-1:0] a_den;
        logic signed [OPERAND_WIDTH-1:0] b_num;
        logic signed [OPERAND_WIDTH-1:0] b_den;
    } frm_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] prod_num;
        logic signed [OUT_W-1:0] prod_den;
    } frm_out_t;

    // classified work item passed from the front to the back
    typedef struct packed {
        logic [PROD_W-1:0] num_mag;
        logic [PROD_W-1:0] den_mag;
        logic              num_neg;
        logic              den_neg;
        logic              reduce;
    } frm_work_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_GCD,
        BK_DIV_NUM,
        BK_DIV_DEN,
        BK_DONE
    } frm_back_state_t;

endpackage

@@ rtl/frm_front.sv @@
// front stage: operand magnitudes, signs and the two products
module frm_front
    import frm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  frm_in_t   operands,
    output logic      work_push,
    input  logic      work_full,
    output frm_work_t work_item
);

    function automatic logic [OPERAND_WIDTH-1:0] mag_of(input logic [OPERAND_WIDTH-1:0] v);
        mag_of = v[OPERAND_WIDTH-1] ? (~v + OPERAND_WIDTH'(1)) : v;
    endfunction

    logic                     stage_valid_reg;
    logic                     stage_valid_next;
    frm_work_t                stage_item_reg;
    frm_work_t                stage_item_next;
    logic                     accept;
    logic [OPERAND_WIDTH-1:0] an_mag;
    logic [OPERAND_WIDTH-1:0] ad_mag;
    logic [OPERAND_WIDTH-1:0] bn_mag;
    logic [OPERAND_WIDTH-1:0] bd_mag;
    logic [PROD_W-1:0]        num_prod;
    logic [PROD_W-1:0]        den_prod;

    assign full      = stage_valid_reg && work_full;
    assign accept    = push && !full;
    assign work_push = stage_valid_reg;
    assign work_item = stage_item_reg;

    always_comb
    begin
        an_mag   = mag_of(operands.a_num);
        ad_mag   = mag_of(operands.a_den);
        bn_mag   = mag_of(operands.b_num);
        bd_mag   = mag_of(operands.b_den);
        num_prod = PROD_W'(an_mag) * PROD_W'(bn_mag);
        den_prod = PROD_W'(ad_mag) * PROD_W'(bd_mag);

        stage_item_next.num_mag = num_prod;
        stage_item_next.den_mag = den_prod;
        stage_item_next.num_neg = (num_prod != '0)
                                  && (operands.a_num[OPERAND_WIDTH-1]
                                      != operands.b_num[OPERAND_WIDTH-1]);
        stage_item_next.den_neg = (den_prod != '0)
                                  && (operands.a_den[OPERAND_WIDTH-1]
                                      != operands.b_den[OPERAND_WIDTH-1]);
        stage_item_next.reduce  = (num_prod != '0) && (den_prod != '0);

        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (stage_valid_reg && !work_full)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_item_reg <= stage_item_next;
        end
    end

endmodule

@@ rtl/frm_queue.sv @@
// two-entry work queue between front and back
module frm_queue
    import frm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_push,
    output logic      wr_full,
    input  frm_work_t wr_item,
    input  logic      rd_pop,
    output logic      rd_valid,
    output frm_work_t rd_item
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    frm_work_t           entry_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [PTR_W:0]      count_reg;
    logic [PTR_W:0]      count_next;
    logic                do_wr;
    logic                do_rd;

    assign wr_full  = (count_reg == (PTR_W+1)'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_push && !wr_full;
    assign do_rd    = rd_pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + (PTR_W+1)'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

@@ rtl/frm_back.sv @@
// back end: binary gcd, two shift-subtract divisions, result register
module frm_back
    import frm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      work_valid,
    output logic      work_pop,
    input  frm_work_t work_item,
    output logic      empty,
    input  logic      pop,
    output frm_out_t  result
);

    localparam int EXT_W = (PROD_W > OUT_W) ? PROD_W : OUT_W;

    function automatic logic [OUT_W-1:0] to_field(input logic [PROD_W-1:0] mag,
                                                  input logic neg);
        logic [EXT_W-1:0] ext;
        ext      = EXT_W'(mag);
        ext      = neg ? (~ext + EXT_W'(1)) : ext;
        to_field = ext[OUT_W-1:0];
    endfunction

    frm_back_state_t   state_reg;
    frm_back_state_t   state_next;
    logic [PROD_W-1:0] num_reg;
    logic [PROD_W-1:0] num_next;
    logic [PROD_W-1:0] den_reg;
    logic [PROD_W-1:0] den_next;
    logic              num_neg_reg;
    logic              num_neg_next;
    logic              den_neg_reg;
    logic              den_neg_next;
    logic [PROD_W-1:0] x_reg;
    logic [PROD_W-1:0] x_next;
    logic [PROD_W-1:0] y_reg;
    logic [PROD_W-1:0] y_next;
    logic [STEP_W-1:0] k_reg;
    logic [STEP_W-1:0] k_next;
    logic [PROD_W-1:0] g_reg;
    logic [PROD_W-1:0] g_next;
    logic [PROD_W-1:0] rem_reg;
    logic [PROD_W-1:0] rem_next;
    logic [PROD_W-1:0] quo_reg;
    logic [PROD_W-1:0] quo_next;
    logic [STEP_W-1:0] cnt_reg;
    logic [STEP_W-1:0] cnt_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    frm_out_t          out_reg;
    frm_out_t          out_next;
    logic [PROD_W:0]   trial;
    logic              fits;
    logic [PROD_W-1:0] rem_step;
    logic [PROD_W-1:0] quo_step;
    logic              last_step;

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    // one restoring division step shared by both divisions
    always_comb
    begin
        trial     = {rem_reg, quo_reg[PROD_W-1]};
        fits      = (trial >= {1'b0, g_reg});
        rem_step  = fits ? PROD_W'(trial - {1'b0, g_reg}) : trial[PROD_W-1:0];
        quo_step  = {quo_reg[PROD_W-2:0], fits};
        last_step = (cnt_reg == STEP_W'(PROD_W - 1));
    end

    always_comb
    begin
        state_next     = state_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        num_neg_next   = num_neg_reg;
        den_neg_next   = den_neg_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        k_next         = k_reg;
        g_next         = g_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        work_pop       = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (work_valid)
                begin
                    work_pop     = 1'b1;
                    num_next     = work_item.num_mag;
                    den_next     = work_item.den_mag;
                    num_neg_next = work_item.num_neg;
                    den_neg_next = work_item.den_neg;
                    x_next       = work_item.num_mag;
                    y_next       = work_item.den_mag;
                    k_next       = '0;
                    state_next   = work_item.reduce ? BK_GCD : BK_DONE;
                end
            end
            BK_GCD:
            begin
                if (x_reg == y_reg)
                begin
                    g_next     = x_reg << k_reg;
                    rem_next   = '0;
                    quo_next   = num_reg;
                    cnt_next   = '0;
                    state_next = BK_DIV_NUM;
                end
                else if (!x_reg[0] && !y_reg[0])
                begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    k_next = k_reg + STEP_W'(1);
                end
                else if (!x_reg[0])
                begin
                    x_next = x_reg >> 1;
                end
                else if (!y_reg[0])
                begin
                    y_next = y_reg >> 1;
                end
                else if (x_reg > y_reg)
                begin
                    x_next = (x_reg - y_reg) >> 1;
                end
                else
                begin
                    y_next = (y_reg - x_reg) >> 1;
                end
            end
            BK_DIV_NUM:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg + STEP_W'(1);
                if (last_step)
                begin
                    num_next   = quo_step;
                    rem_next   = '0;
                    quo_next   = den_reg;
                    cnt_next   = '0;
                    state_next = BK_DIV_DEN;
                end
            end
            BK_DIV_DEN:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg + STEP_W'(1);
                if (last_step)
                begin
                    den_next   = quo_step;
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_next.prod_num = to_field(num_reg, num_neg_reg);
                    out_next.prod_den = to_field(den_reg, den_neg_reg);
                    out_valid_next    = 1'b1;
                    state_next        = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg     <= num_next;
        den_reg     <= den_next;
        num_neg_reg <= num_neg_next;
        den_neg_reg <= den_neg_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        k_reg       <= k_next;
        g_reg       <= g_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
        out_reg     <= out_next;
    end

endmodule

@@ rtl/fraction_multiply_reduce_unit.sv @@
// fraction multiply and reduce unit: top level
// when both products are nonzero, a transaction passes the front stage, the queue, a binary gcd loop
// and then two 32-step divisions; when a product is zero, the back skips the gcd and both divisions
// throughput: one transaction per back-end pass; the back holds in BK_DONE while an earlier result is not popped
// the front stage and a two-entry queue take up to three more transactions while the back is busy
// reset: asynchronous, active low; clears all handshake and sequencer state, payload registers are not reset
module fraction_multiply_reduce_unit
    import frm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    // input side, queue style: accepted when push is high and full is low
    input  logic     push,
    output logic     full,
    input  frm_in_t  operands,
    // result side, queue style: accepted when pop is high and empty is low
    output logic     empty,
    input  logic     pop,
    output frm_out_t result
);

    // front to queue handshake
    logic      front_push;
    logic      front_full;
    frm_work_t front_item;
    // queue to back handshake
    logic      work_valid;
    logic      work_pop;
    frm_work_t work_item;

    // front: magnitudes and signs of the operands, both products, zero check
    frm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .operands  (operands),
        .work_push (front_push),
        .work_full (front_full),
        .work_item (front_item)
    );

    // short queue so the front keeps taking transactions while the back iterates
    frm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_push  (front_push),
        .wr_full  (front_full),
        .wr_item  (front_item),
        .rd_pop   (work_pop),
        .rd_valid (work_valid),
        .rd_item  (work_item)
    );

    // back: gcd of the product magnitudes, exact division of each, sign restore
    frm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work_valid (work_valid),
        .work_pop   (work_pop),
        .work_item  (work_item),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

endmodule
